// File: rtl/core/pole_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pole_pkg
// Shared types for the positional ordered list engine: request and result
// words, request kinds, status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package pole_pkg;

    typedef enum logic [2:0] {
        K_INS_AT    = 3'd0,
        K_INS_FRONT = 3'd1,
        K_INS_BACK  = 3'd2,
        K_REM_FIRST = 3'd3,
        K_REM_LAST  = 3'd4,
        K_REM_AT    = 3'd5,
        K_READ_AT   = 3'd6,
        K_FIND      = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_RANGE   = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_FULL    = 3'd3,
        ST_MISSING = 3'd4
    } t_status;

    typedef struct packed {
        t_kind              kind;
        logic signed [31:0] item_value;
        logic [4:0]         position;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] read_value;
        logic [3:0]         found_index;
        logic [4:0]         list_length;
    } t_res;

    // read address relative to the walking index
    typedef enum logic [1:0] {
        RD_IDX  = 2'd0,
        RD_PREV = 2'd1,
        RD_NEXT = 2'd2
    } t_rd_sel;

    typedef enum logic [2:0] {
        IDX_HOLD  = 3'd0,
        IDX_COUNT = 3'd1,
        IDX_POS   = 3'd2,
        IDX_ZERO  = 3'd3,
        IDX_INC   = 3'd4,
        IDX_DEC   = 3'd5
    } t_idx_op;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        logic    wr_val;
        t_idx_op idx_op;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    set_status;
        t_status status;
        logic    take_read;
        logic    take_found;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  empty;
        logic  full;
        logic  pos_gt_count;
        logic  pos_ge_count;
        logic  idx_gt_pos;
        logic  next_lt_count;
        logic  idx_last;
        logic  match;
    } t_flags;

endpackage

// File: rtl/core/positional_ordered_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_ordered_list_engine
// Bounded ordered list of signed 32-bit values with positional insert,
// remove, read and find; one request at a time, one result word each.
// ----------------------------------------------------------------------------
// A request word is taken on a clock edge where start is high and busy is
// low; busy then stays high until the result word has been shown on o_res
// for the single cycle that o_done is high, and the next request can be
// taken in the cycle after that. The result cannot be held off, so it must be
// captured on that edge. Entries live in a memory with separate read and
// write ports, one read and one write a cycle; a shift moves each entry
// with a read and then a write. Insert at p (front p = 0, back p = n for
// n entries) shifts entries from p up, remove at p (first p = 0) shifts
// later entries down, remove last shifts none, and find stops at the
// first match or the last entry. No clearing pass follows reset.
module positional_ordered_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  pole_pkg::t_req i_req,
    output logic           busy,
    output logic           o_done,
    output pole_pkg::t_res o_res
);

    pole_pkg::t_cmd   w_cmd;
    pole_pkg::t_flags w_flags;

    pole_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_flags (w_flags),
        .o_cmd   (w_cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    pole_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (w_cmd),
        .o_flags (w_flags),
        .o_res   (o_res)
    );

`ifndef ASSERT_OFF
    a_done_then_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("engine still busy after its result word");

    a_accept_no_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("result word in the cycle right after a request");

    a_full_length : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status == pole_pkg::ST_FULL) |->
        (o_res.list_length == 5'(CAPACITY)))
        else $error("full status with a list that is not full");

    a_fail_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.status != pole_pkg::ST_OK) |->
        (o_res.read_value == '0 && o_res.found_index == '0))
        else $error("failed request returned read or find data");
`endif

endmodule

// File: rtl/core/pole_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pole_dp
// Datapath: entry memory, entry count, walking index, request and result
// registers, driven by controller commands.
// ----------------------------------------------------------------------------
module pole_dp #(
    parameter int CAPACITY = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pole_pkg::t_req  i_req,
    input  pole_pkg::t_cmd  i_cmd,
    output pole_pkg::t_flags o_flags,
    output pole_pkg::t_res  o_res
);

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = (IW > 5) ? IW : 5;

    logic [31:0]        r_mem [CAPACITY];
    logic [31:0]        r_rdata;
    logic [IW-1:0]      r_count;
    logic [IW-1:0]      r_idx;
    logic [CW-1:0]      r_pos;
    logic signed [31:0] r_value;
    pole_pkg::t_kind    r_kind;
    pole_pkg::t_status  r_status;
    logic signed [31:0] r_read_value;
    logic [IW-1:0]      r_found;

    logic [CW-1:0] n_pos;
    logic [IW-1:0] n_idx;
    logic [IW:0]   w_next_ext;
    logic [IW-1:0] w_rd_idx;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;
    logic [31:0]   w_wdata;

    // front and first act at slot zero, back appends at the count
    always_comb begin
        unique case (i_req.kind)
            pole_pkg::K_INS_FRONT, pole_pkg::K_REM_FIRST: n_pos = '0;
            pole_pkg::K_INS_BACK:                         n_pos = CW'(r_count);
            default:                                      n_pos = CW'(i_req.position);
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        unique case (i_cmd.idx_op)
            pole_pkg::IDX_HOLD:  n_idx = r_idx;
            pole_pkg::IDX_COUNT: n_idx = r_count;
            pole_pkg::IDX_POS:   n_idx = r_pos[IW-1:0];
            pole_pkg::IDX_ZERO:  n_idx = '0;
            pole_pkg::IDX_INC:   n_idx = r_idx + IW'(1);
            pole_pkg::IDX_DEC:   n_idx = r_idx - IW'(1);
            default:             n_idx = r_idx;
        endcase
    end

    assign w_next_ext = {1'b0, r_idx} + (IW + 1)'(1);

    always_comb begin
        unique case (i_cmd.rd_sel)
            pole_pkg::RD_PREV: w_rd_idx = r_idx - IW'(1);
            pole_pkg::RD_NEXT: w_rd_idx = w_next_ext[IW-1:0];
            default:           w_rd_idx = r_idx;
        endcase
    end

    assign w_rd_addr = w_rd_idx[AW-1:0];
    assign w_wr_addr = r_idx[AW-1:0];
    assign w_wdata   = i_cmd.wr_val ? r_value : r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_wr_addr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_count <= r_count + IW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_kind       <= i_req.kind;
            r_value      <= i_req.item_value;
            r_pos        <= n_pos;
            r_status     <= pole_pkg::ST_OK;
            r_read_value <= '0;
            r_found      <= '0;
        end else begin
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status;
            end
            if (i_cmd.take_read) begin
                r_read_value <= r_rdata;
            end
            if (i_cmd.take_found) begin
                r_found <= r_idx;
            end
        end
    end

    assign o_flags.kind          = r_kind;
    assign o_flags.empty         = (r_count == '0);
    assign o_flags.full          = (r_count >= IW'(CAPACITY));
    assign o_flags.pos_gt_count  = (r_pos > CW'(r_count));
    assign o_flags.pos_ge_count  = (r_pos >= CW'(r_count));
    assign o_flags.idx_gt_pos    = (CW'(r_idx) > r_pos);
    assign o_flags.next_lt_count = (w_next_ext < {1'b0, r_count});
    assign o_flags.idx_last      = (w_next_ext == {1'b0, r_count});
    assign o_flags.match         = (r_rdata == r_value);

    assign o_res.status      = r_status;
    assign o_res.read_value  = r_read_value;
    assign o_res.found_index = 4'(r_found);
    assign o_res.list_length = 5'(r_count);

endmodule

// File: rtl/core/pole_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pole_ctrl
// Controller: checks each request, steps the datapath through the shift,
// read or search walk that an accepted request needs and raises the done strobe.
// ----------------------------------------------------------------------------
module pole_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  pole_pkg::t_flags i_flags,
    output pole_pkg::t_cmd   o_cmd,
    output logic             busy,
    output logic             o_done
);

    typedef enum logic [10:0] {
        S_IDLE       = 11'b000_0000_0001,
        S_CHECK      = 11'b000_0000_0010,
        S_INS_LOOP   = 11'b000_0000_0100,
        S_INS_MOVE   = 11'b000_0000_1000,
        S_REM_LOOP   = 11'b000_0001_0000,
        S_REM_MOVE   = 11'b000_0010_0000,
        S_RD_ISSUE   = 11'b000_0100_0000,
        S_RD_TAKE    = 11'b000_1000_0000,
        S_FIND_ISSUE = 11'b001_0000_0000,
        S_FIND_CMP   = 11'b010_0000_0000,
        S_RESP       = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_RESP;
                unique case (i_flags.kind)
                    pole_pkg::K_INS_AT: begin
                        if (i_flags.pos_gt_count) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = pole_pkg::ST_RANGE;
                        end else if (i_flags.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = pole_pkg::ST_FULL;
                        end else begin
                            o_cmd.idx_op = pole_pkg::IDX_COUNT;
                            n_state      = S_INS_LOOP;
                        end
                    end
                    pole_pkg::K_INS_FRONT, pole_pkg::K_INS_BACK: begin
                        if (i_flags.full) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = pole_pkg::ST_FULL;
                        end else begin
                            o_cmd.idx_op = pole_pkg::IDX_COUNT;
                            n_state      = S_INS_LOOP;
                        end
                    end
                    pole_pkg::K_REM_FIRST: begin
                        if (i_flags.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = pole_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.idx_op = pole_pkg::IDX_POS;
                            n_state      = S_REM_LOOP;
                        end
                    end
                    pole_pkg::K_REM_LAST: begin
                        if (i_flags.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = pole_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.cnt_dec = 1'b1;
                        end
                    end
                    pole_pkg::K_REM_AT, pole_pkg::K_READ_AT: begin
                        if (i_flags.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = pole_pkg::ST_EMPTY;
                        end else if (i_flags.pos_ge_count) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = pole_pkg::ST_RANGE;
                        end else begin
                            o_cmd.idx_op = pole_pkg::IDX_POS;
                            n_state = (i_flags.kind == pole_pkg::K_REM_AT) ?
                                      S_REM_LOOP : S_RD_ISSUE;
                        end
                    end
                    pole_pkg::K_FIND: begin
                        if (i_flags.empty) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status     = pole_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.idx_op = pole_pkg::IDX_ZERO;
                            n_state      = S_FIND_ISSUE;
                        end
                    end
                endcase
            end
            // walk down from the count, moving each entry one slot up
            S_INS_LOOP: begin
                if (i_flags.idx_gt_pos) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = pole_pkg::RD_PREV;
                    n_state      = S_INS_MOVE;
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_val  = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_RESP;
                end
            end
            S_INS_MOVE: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.idx_op = pole_pkg::IDX_DEC;
                n_state      = S_INS_LOOP;
            end
            // walk up from the hole, pulling each later entry down
            S_REM_LOOP: begin
                if (i_flags.next_lt_count) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = pole_pkg::RD_NEXT;
                    n_state      = S_REM_MOVE;
                end else begin
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_RESP;
                end
            end
            S_REM_MOVE: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.idx_op = pole_pkg::IDX_INC;
                n_state      = S_REM_LOOP;
            end
            S_RD_ISSUE: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = pole_pkg::RD_IDX;
                n_state      = S_RD_TAKE;
            end
            S_RD_TAKE: begin
                o_cmd.take_read = 1'b1;
                n_state         = S_RESP;
            end
            S_FIND_ISSUE: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = pole_pkg::RD_IDX;
                n_state      = S_FIND_CMP;
            end
            S_FIND_CMP: begin
                priority if (i_flags.match) begin
                    o_cmd.take_found = 1'b1;
                    n_state          = S_RESP;
                end else if (i_flags.idx_last) begin
                    o_cmd.set_status = 1'b1;
                    o_cmd.status     = pole_pkg::ST_MISSING;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.idx_op = pole_pkg::IDX_INC;
                    n_state      = S_FIND_ISSUE;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_RESP);

endmodule
